### rtl/sha256_pkg.sv
// Shared types, constants and functions for the SHA-256 byte stream hasher.
`timescale 1ns / 1ps
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } sha_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take_byte;    // write byte, bump length
        logic pad_start;    // write 0x80 at current position
        logic pad_zero_fill; // zero words after pad position
        logic clear_block;  // zero whole block
        logic put_length;   // write length into words 14,15
        logic load_work;    // working vars <= chain
        logic do_round;     // one compression round
        logic fold;         // chain += working vars
        logic reset_state;  // chain <= IV, length <= 0
        logic emit;         // drive digest word
    } sha_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic       block_full;  // position is 63: this byte completes the block
        logic       last_round;
        logic       pad_two;     // pad position >= 56
        logic       last_emit;
    } sha_stat_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
        32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
        rotr = (v >> s) | (v << (32 - s));
    endfunction

endpackage

### rtl/sha256_ctrl.sv
// Controller state machine sequencing bytes, rounds, padding and digest output.
`timescale 1ns / 1ps
module sha256_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   byte_present,
    input  logic                   end_of_message,
    input  sha256_pkg::sha_stat_t  stat,
    output sha256_pkg::sha_cmd_t   cmd,
    output logic                   busy
);
    import sha256_pkg::*;

    sha_state_t state_reg, state_next;
    logic       final_reg, final_next;   // padding still pending after this block
    logic       last_blk_reg, last_blk_next; // block being compressed is the last

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            final_reg    <= 1'b0;
            last_blk_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            final_reg    <= final_next;
            last_blk_reg <= last_blk_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        final_next    = final_reg;
        last_blk_next = last_blk_reg;
        cmd           = '0;
        busy          = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.take_byte = byte_present;
                    if (byte_present && stat.block_full)
                    begin
                        cmd.load_work = 1'b1;
                        final_next    = end_of_message;
                        last_blk_next = 1'b0;
                        state_next    = ST_ROUND;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                cmd.do_round = 1'b1;
                if (stat.last_round)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
                if (last_blk_reg)
                    state_next = ST_EMIT;
                else if (final_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_PAD:
            begin
                // position still valid here; decide one or two blocks
                cmd.load_work = 1'b1;
                state_next    = ST_ROUND;
                final_next    = 1'b0;
                if (final_reg && stat.pad_two)
                begin
                    // second block after a pad overflow: zeros plus length
                    cmd.clear_block = 1'b1;
                    cmd.put_length  = 1'b1;
                    last_blk_next   = 1'b1;
                end
                else if (stat.pad_two)
                begin
                    cmd.pad_start     = 1'b1;
                    cmd.pad_zero_fill = 1'b1;
                    final_next        = 1'b1;
                    last_blk_next     = 1'b0;
                end
                else
                begin
                    cmd.pad_start     = 1'b1;
                    cmd.pad_zero_fill = 1'b1;
                    cmd.put_length    = 1'b1;
                    last_blk_next     = 1'b1;
                end
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (stat.last_emit)
                begin
                    cmd.reset_state = 1'b1;
                    last_blk_next   = 1'b0;
                    final_next      = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/sha256_datapath.sv
// Datapath: block buffer, schedule window, working variables, chain and length.
`timescale 1ns / 1ps
module sha256_datapath
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            msg_byte,
    input  sha256_pkg::sha_cmd_t  cmd,
    output sha256_pkg::sha_stat_t stat,
    output logic [31:0]           digest_word,
    output logic [2:0]            word_index,
    output logic                  last_word,
    output logic                  result_valid
);
    import sha256_pkg::*;

    logic [31:0] blk_reg [16];
    logic [31:0] wv_reg [8];
    logic [31:0] chain_reg [8];
    logic [63:0] len_reg;
    logic [5:0]  rnd_reg;
    logic [2:0]  emit_reg;
    logic [31:0] dout_reg;
    logic [2:0]  idx_reg;
    logic        last_reg, valid_reg;

    logic [5:0]  pos;
    logic [3:0]  t;
    logic [31:0] w15, w2, s0, s1, wt, wnew;
    logic [31:0] big0, big1, chs, mj, t1;

    assign pos = len_reg[8:3];
    assign t   = rnd_reg[3:0];

    // Schedule extension and round function
    always_comb
    begin
        w15  = blk_reg[t + 4'd1];
        w2   = blk_reg[t + 4'd14];
        s0   = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        s1   = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        wnew = blk_reg[t] + s0 + blk_reg[t + 4'd9] + s1;
        wt   = (rnd_reg >= 6'd16) ? wnew : blk_reg[t];
        big1 = rotr(wv_reg[4], 6) ^ rotr(wv_reg[4], 11) ^ rotr(wv_reg[4], 25);
        chs  = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
        t1   = wv_reg[7] + big1 + chs + ROUND_K[rnd_reg] + wt;
        big0 = rotr(wv_reg[0], 2) ^ rotr(wv_reg[0], 13) ^ rotr(wv_reg[0], 22);
        mj   = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2])
             ^ (wv_reg[1] & wv_reg[2]);
    end

    assign stat.block_full = (pos == 6'd63);
    assign stat.last_round = (rnd_reg == 6'd63);
    assign stat.pad_two    = (pos >= LEN_POS);
    assign stat.last_emit  = (emit_reg == 3'd7);

    // Block buffer: bytes, padding, length, schedule
    always_ff @(posedge clk)
    begin
        if (cmd.take_byte)
        begin
            case (pos[1:0])
                2'd0:    blk_reg[pos[5:2]][31:24] <= msg_byte;
                2'd1:    blk_reg[pos[5:2]][23:16] <= msg_byte;
                2'd2:    blk_reg[pos[5:2]][15:8]  <= msg_byte;
                default: blk_reg[pos[5:2]][7:0]   <= msg_byte;
            endcase
        end
        if (cmd.clear_block)
        begin
            for (int i = 0; i < 16; i++)
                blk_reg[i] <= '0;
        end
        if (cmd.pad_zero_fill)
        begin
            for (int i = 0; i < 16; i++)
            begin
                if (4'(i) > pos[5:2])
                    blk_reg[i] <= '0;
            end
        end
        if (cmd.pad_start)
        begin
            case (pos[1:0])
                2'd0:    blk_reg[pos[5:2]] <= {PAD_BYTE, 24'h0};
                2'd1:    blk_reg[pos[5:2]][23:0] <= {PAD_BYTE, 16'h0};
                2'd2:    blk_reg[pos[5:2]][15:0] <= {PAD_BYTE, 8'h0};
                default: blk_reg[pos[5:2]][7:0] <= PAD_BYTE;
            endcase
        end
        if (cmd.put_length)
        begin
            blk_reg[14] <= len_reg[63:32];
            blk_reg[15] <= len_reg[31:0];
        end
        if (cmd.do_round && rnd_reg >= 6'd16)
            blk_reg[t] <= wnew;
    end

    // Working variables
    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
        begin
            for (int i = 0; i < 8; i++)
                wv_reg[i] <= chain_reg[i];
        end
        else if (cmd.do_round)
        begin
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= wv_reg[4];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= t1 + big0 + mj;
        end
    end

    // Chain, length, counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= INIT_HASH[i];
            len_reg   <= '0;
            rnd_reg   <= '0;
            emit_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
            if (cmd.take_byte)
                len_reg <= len_reg + 64'd8;
            if (cmd.do_round)
                rnd_reg <= rnd_reg + 6'd1;
            if (cmd.fold)
            begin
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= chain_reg[i] + wv_reg[i];
            end
            if (cmd.emit)
                emit_reg <= emit_reg + 3'd1;
            if (cmd.reset_state)
            begin
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= INIT_HASH[i];
                len_reg  <= '0;
                emit_reg <= '0;
            end
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        dout_reg <= chain_reg[emit_reg];
        idx_reg  <= emit_reg;
        last_reg <= (emit_reg == 3'd7);
    end

    assign digest_word  = dout_reg;
    assign word_index   = idx_reg;
    assign last_word    = last_reg;
    assign result_valid = valid_reg;

endmodule

### rtl/sha256_byte_stream_hasher_top.sv
// SHA-256 over a byte stream (FIPS 180-4): one message byte per command, digest on the
// final command. A byte that does not complete a 64-byte block leaves the hasher idle. A
// byte that completes a block starts its compression: the accept cycle, which also loads
// the working variables, 64 rounds of the single round unit and a fold. The final command
// then runs each padded block (one, or two when fewer than nine bytes of room are left)
// through the pad state, 64 rounds and a fold, then outputs the eight digest words, one
// per cycle with digest_valid high, word 0 first, each word registered and shown in the
// cycle after its output cycle. The receiver cannot stall, so it must take each word in
// its cycle. busy is low only when a new command can be taken.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  msg_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        digest_valid,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha256_pkg::*;

    sha_cmd_t  cmd;
    sha_stat_t stat;

    sha256_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .stat           (stat),
        .cmd            (cmd),
        .busy           (busy)
    );

    sha256_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_byte     (msg_byte),
        .cmd          (cmd),
        .stat         (stat),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .last_word    (last_word),
        .result_valid (digest_valid)
    );

endmodule
